@@ sv/button_click_event_detector_defines.svh @@
// Assertion macros for the button click event detector.
`ifndef BUTTON_CLICK_EVENT_DETECTOR_DEFINES_SVH
`define BUTTON_CLICK_EVENT_DETECTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCED_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("button_click_event_detector: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define BCED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("button_click_event_detector: next-cycle property failed");

`endif

@@ sv/bced_pkg.sv @@
// Types and constants shared by the button click event detector.
package bced_pkg;

    localparam int FLAG_W = 7;

    typedef logic [FLAG_W-1:0] flags_t;

    localparam int FLAG_HOLD_BIT   = 0;
    localparam int FLAG_DOWN_BIT   = 1;
    localparam int FLAG_UP_BIT     = 2;
    localparam int FLAG_SINGLE_BIT = 3;
    localparam int FLAG_DOUBLE_BIT = 4;
    localparam int FLAG_LONG_BIT   = 5;
    localparam int FLAG_REPEAT_BIT = 6;

    localparam flags_t FLAG_HOLD = 7'h01;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    typedef enum logic [2:0] {
        CLICK_IDLE        = 3'd0,
        CLICK_PRESSED     = 3'd1,
        CLICK_WAIT_SECOND = 3'd2,
        CLICK_SECOND_HELD = 3'd3,
        CLICK_REPEATING   = 3'd4
    } click_state_t;

    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_SAMPLE_DIVIDER  = 3'd0;
    localparam logic [2:0] REG_DOUBLE_WINDOW   = 3'd1;
    localparam logic [2:0] REG_LONG_TIME       = 3'd2;
    localparam logic [2:0] REG_REPEAT_INTERVAL = 3'd3;
    localparam logic [2:0] REG_ACTIVE_LOW      = 3'd4;

    localparam logic [7:0]  RST_SAMPLE_DIVIDER  = 8'd20;
    localparam logic [15:0] RST_DOUBLE_WINDOW   = 16'd200;
    localparam logic [15:0] RST_LONG_TIME       = 16'd1200;
    localparam logic [15:0] RST_REPEAT_INTERVAL = 16'd100;
    localparam logic        RST_ACTIVE_LOW      = 1'b1;

endpackage

@@ sv/button_click_event_detector.sv @@
// Per-key button event detector: hold, edge, single, double, long and repeat flags.
//
// Items enter an input register and are worked on from there by the per-key
// update logic, which writes the key state and the result register together. The
// block takes one item per cycle unless out_stall holds a waiting result; a result
// is presented from the result register once its item leaves the input register,
// and the update of all keys in parallel sits between the two registers. A tick
// (operation 0) counts every key timer down and, every sample_divider ticks, samples
// pin_levels; a check (operation 1) tests flag_mask against the flags of key key_index
// and clears those flags unless the mask is exactly the hold flag.
// Each item gives one result with check_hit and the key's flags after the item.
// Configuration goes through the APB port at byte address 4*i; the user must write it only while idle (not enforced).
`include "button_click_event_detector_defines.svh"

module button_click_event_detector #(
    parameter int NUM_KEYS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [3:0]                    pin_levels,
    input  logic [1:0]                    key_index,
    input  logic [6:0]                    flag_mask,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          check_hit,
    output logic [6:0]                    key_flags,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bced_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // Configuration registers
    logic [7:0]  sample_divider_reg;
    logic [15:0] double_window_reg;
    logic [15:0] long_time_reg;
    logic [15:0] repeat_interval_reg;
    logic        active_low_reg;

    logic        cfg_write;
    logic [2:0]  cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[bced_pkg::PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_divider_reg  <= bced_pkg::RST_SAMPLE_DIVIDER;
            double_window_reg   <= bced_pkg::RST_DOUBLE_WINDOW;
            long_time_reg       <= bced_pkg::RST_LONG_TIME;
            repeat_interval_reg <= bced_pkg::RST_REPEAT_INTERVAL;
            active_low_reg      <= bced_pkg::RST_ACTIVE_LOW;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bced_pkg::REG_SAMPLE_DIVIDER:  sample_divider_reg  <= pwdata[7:0];
                bced_pkg::REG_DOUBLE_WINDOW:   double_window_reg   <= pwdata[15:0];
                bced_pkg::REG_LONG_TIME:       long_time_reg       <= pwdata[15:0];
                bced_pkg::REG_REPEAT_INTERVAL: repeat_interval_reg <= pwdata[15:0];
                bced_pkg::REG_ACTIVE_LOW:      active_low_reg      <= pwdata[0];
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            bced_pkg::REG_SAMPLE_DIVIDER:  prdata = {24'd0, sample_divider_reg};
            bced_pkg::REG_DOUBLE_WINDOW:   prdata = {16'd0, double_window_reg};
            bced_pkg::REG_LONG_TIME:       prdata = {16'd0, long_time_reg};
            bced_pkg::REG_REPEAT_INTERVAL: prdata = {16'd0, repeat_interval_reg};
            bced_pkg::REG_ACTIVE_LOW:      prdata = {31'd0, active_low_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    // Pipeline control: input register feeds the update, result register feeds out
    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic [3:0]  s1_pins_reg;
    logic [1:0]  s1_index_reg;
    logic [6:0]  s1_mask_reg;
    logic        out_valid_reg;
    logic        check_hit_reg;
    logic [6:0]  key_flags_reg;
    logic        advance;
    logic        fire;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_op_reg    <= operation;
            s1_pins_reg  <= pin_levels;
            s1_index_reg <= key_index;
            s1_mask_reg  <= flag_mask;
        end
    end

    // Key state
    logic [7:0]             sample_count_reg;
    logic [7:0]             sample_count_next;
    logic [7:0]             count_inc;
    logic                   is_tick;
    logic                   do_sample;
    logic                   index_valid;
    logic [NUM_KEYS-1:0]    key_sel;

    logic [NUM_KEYS-1:0]    pressed_reg;
    logic [NUM_KEYS-1:0]    pressed_next;
    logic [NUM_KEYS-1:0]    now_pressed;
    logic [15:0]            timer_reg   [NUM_KEYS];
    logic [15:0]            timer_next  [NUM_KEYS];
    logic [15:0]            timer_dec   [NUM_KEYS];
    bced_pkg::flags_t       flags_reg   [NUM_KEYS];
    bced_pkg::flags_t       flags_next  [NUM_KEYS];
    bced_pkg::click_state_t click_reg   [NUM_KEYS];
    bced_pkg::click_state_t click_next  [NUM_KEYS];

    assign is_tick     = (s1_op_reg == bced_pkg::OP_TICK);
    assign count_inc   = sample_count_reg + 8'd1;
    assign do_sample   = is_tick && (count_inc >= sample_divider_reg);
    assign index_valid = (int'(s1_index_reg) < NUM_KEYS);

    always_comb
    begin
        if (is_tick)
        begin
            sample_count_next = do_sample ? 8'd0 : count_inc;
        end
        else
        begin
            sample_count_next = sample_count_reg;
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        if (k < 4)
        begin : g_pin
            assign now_pressed[k] = s1_pins_reg[k] ^ active_low_reg;
        end
        else
        begin : g_nopin
            assign now_pressed[k] = active_low_reg;
        end
        assign key_sel[k]   = (int'(s1_index_reg) == k);
        assign timer_dec[k] = (timer_reg[k] != 16'd0) ? timer_reg[k] - 16'd1 : 16'd0;
    end

    // Next click state of every key
    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            click_next[k] = click_reg[k];
            if (do_sample)
            begin
                case (click_reg[k])
                    bced_pkg::CLICK_PRESSED:
                    begin
                        if (!now_pressed[k])
                            click_next[k] = bced_pkg::CLICK_WAIT_SECOND;
                        else if (timer_dec[k] == 16'd0)
                            click_next[k] = bced_pkg::CLICK_REPEATING;
                    end
                    bced_pkg::CLICK_WAIT_SECOND:
                    begin
                        if (now_pressed[k])
                            click_next[k] = bced_pkg::CLICK_SECOND_HELD;
                        else if (timer_dec[k] == 16'd0)
                            click_next[k] = bced_pkg::CLICK_IDLE;
                    end
                    bced_pkg::CLICK_SECOND_HELD,
                    bced_pkg::CLICK_REPEATING:
                    begin
                        if (!now_pressed[k])
                            click_next[k] = bced_pkg::CLICK_IDLE;
                    end
                    default:
                    begin
                        click_next[k] = now_pressed[k] ? bced_pkg::CLICK_PRESSED
                                                       : bced_pkg::CLICK_IDLE;
                    end
                endcase
            end
        end
    end

    // Timers, pressed level and flags of every key
    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            timer_next[k]   = is_tick ? timer_dec[k] : timer_reg[k];
            pressed_next[k] = pressed_reg[k];
            flags_next[k]   = flags_reg[k];
            if (do_sample)
            begin
                pressed_next[k] = now_pressed[k];
                flags_next[k][bced_pkg::FLAG_HOLD_BIT] = now_pressed[k];
                if (now_pressed[k] && !pressed_reg[k])
                    flags_next[k][bced_pkg::FLAG_DOWN_BIT] = 1'b1;
                if (!now_pressed[k] && pressed_reg[k])
                    flags_next[k][bced_pkg::FLAG_UP_BIT] = 1'b1;
                case (click_reg[k])
                    bced_pkg::CLICK_PRESSED:
                    begin
                        if (!now_pressed[k])
                        begin
                            timer_next[k] = double_window_reg;
                        end
                        else if (timer_dec[k] == 16'd0)
                        begin
                            timer_next[k] = repeat_interval_reg;
                            flags_next[k][bced_pkg::FLAG_LONG_BIT] = 1'b1;
                        end
                    end
                    bced_pkg::CLICK_WAIT_SECOND:
                    begin
                        if (now_pressed[k])
                            flags_next[k][bced_pkg::FLAG_DOUBLE_BIT] = 1'b1;
                        else if (timer_dec[k] == 16'd0)
                            flags_next[k][bced_pkg::FLAG_SINGLE_BIT] = 1'b1;
                    end
                    bced_pkg::CLICK_SECOND_HELD:
                    begin
                        // no further timer or flag action
                    end
                    bced_pkg::CLICK_REPEATING:
                    begin
                        if (now_pressed[k] && timer_dec[k] == 16'd0)
                        begin
                            timer_next[k] = repeat_interval_reg;
                            flags_next[k][bced_pkg::FLAG_REPEAT_BIT] = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (now_pressed[k])
                            timer_next[k] = long_time_reg;
                    end
                endcase
            end
            else if (!is_tick && key_sel[k] && (flags_reg[k] & s1_mask_reg) != '0
                     && s1_mask_reg != bced_pkg::FLAG_HOLD)
            begin
                // clear the tested flags
                flags_next[k] = flags_reg[k] & ~s1_mask_reg;
            end
        end
    end

    // Result of the item
    logic                   hit_next;
    bced_pkg::flags_t       report_next;

    always_comb
    begin
        hit_next    = 1'b0;
        report_next = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (key_sel[k])
            begin
                report_next = flags_next[k];
                hit_next    = !is_tick && ((flags_reg[k] & s1_mask_reg) != '0);
            end
        end
        if (!index_valid)
        begin
            hit_next    = 1'b0;
            report_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= 8'd0;
            pressed_reg      <= '0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                timer_reg[k] <= 16'd0;
                flags_reg[k] <= '0;
                click_reg[k] <= bced_pkg::CLICK_IDLE;
            end
        end
        else if (fire)
        begin
            sample_count_reg <= sample_count_next;
            pressed_reg      <= pressed_next;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                timer_reg[k] <= timer_next[k];
                flags_reg[k] <= flags_next[k];
                click_reg[k] <= click_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            check_hit_reg <= hit_next;
            key_flags_reg <= report_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign check_hit = check_hit_reg;
    assign key_flags = key_flags_reg;

    `BCED_ASSERT_SAME(a_stall_needs_item, in_stall, s1_valid_reg && out_valid_reg)
    `BCED_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_reg)
    `BCED_ASSERT_NEXT(a_tick_no_hit, fire && is_tick, !check_hit_reg)

endmodule
